FILE: design/poc_pkg.sv
// ----------------------------------------------------------------------------
// poc_pkg
// Shared types, constants and helpers for the picture order count decoder.
// ----------------------------------------------------------------------------
package poc_pkg;

    localparam int DATA_W     = 32;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CYC_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [4:0] LOG2_MIN = 5'd4;
    localparam logic [4:0] LOG2_MAX = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_COUNT_TYPE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_MAX_LSB      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_MAX_FRAME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NON_REF_OFFSET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_BOTTOM_OFFSET = 3'd5;

    // order count methods
    localparam logic [1:0] POC_TYPE_LSB    = 2'd0;
    localparam logic [1:0] POC_TYPE_FRAME  = 2'd1;
    localparam logic [1:0] POC_TYPE_DOUBLE = 2'd2;

    // transaction modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic [1:0]        poc_type;
        logic [4:0]        log2_lsb;
        logic [4:0]        log2_fn;
        logic [CYC_W-1:0]  cycle_len;
        logic [DATA_W-1:0] nonref_off;
        logic [DATA_W-1:0] ttb_off;
    } poc_cfg_t;

    typedef struct packed {
        logic              mode;
        logic              is_idr;
        logic [15:0]       frame_number;
        logic [15:0]       order_lsb;
        logic [DATA_W-1:0] delta_first;
        logic [DATA_W-1:0] delta_bottom;
        logic              is_reference;
        logic              is_field;
        logic              is_bottom;
        logic              has_reset_op;
    } poc_item_t;

    typedef struct packed {
        logic idle;
        logic done;
    } poc_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_M0_CMP,
        S_M0_MSB,
        S_M0_TOP,
        S_M0_BOT,
        S_FNO,
        S_M2_SUM,
        S_M2_TEMP,
        S_M1_ABS,
        S_M1_DEC,
        S_M1_ADJ,
        S_M1_DIV,
        S_M1_PRIME,
        S_M1_SWEEP,
        S_M1_MUL,
        S_M1_EXP,
        S_M1_NREF,
        S_M1_TOP,
        S_M1_BOT1,
        S_M1_BOT2,
        S_DONE
    } poc_state_t;

    function automatic logic [4:0] clamp_log2(input logic [4:0] v);
        logic [4:0] r;
        if (v < LOG2_MIN) begin
            r = LOG2_MIN;
        end else if (v > LOG2_MAX) begin
            r = LOG2_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: design/poc_table_ram.sv
// ----------------------------------------------------------------------------
// poc_table_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module poc_table_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/poc_seq.sv
// ----------------------------------------------------------------------------
// poc_seq
// Sequencer and datapath: history registers, one shared 32-bit adder used
// for the order count sums, the divider steps and the table sweep.
// ----------------------------------------------------------------------------
module poc_seq
    import poc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  poc_cfg_t            cfg,
    input  logic                start,
    input  poc_item_t           item_in,
    input  logic                out_free,
    output poc_status_t         status,
    output logic [TABLE_AW-1:0] rd_addr,
    input  logic [DATA_W-1:0]   rd_data,
    output logic [DATA_W-1:0]   top_count,
    output logic [DATA_W-1:0]   bottom_count
);

    poc_state_t state_reg, state_next;
    poc_item_t  item_reg, item_next;

    logic [DATA_W-1:0] prev_msb_reg, prev_msb_next;
    logic [15:0]       prev_lsb_reg, prev_lsb_next;
    logic [15:0]       prev_fn_reg, prev_fn_next;
    logic [DATA_W-1:0] prev_fo_reg, prev_fo_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] bot_reg, bot_next;

    logic [DATA_W-1:0]    acc_reg, acc_next;
    logic [DATA_W-1:0]    tmp_reg, tmp_next;
    logic [DATA_W-1:0]    q_reg, q_next;
    logic [CYC_W-1:0]     r_reg, r_next;
    logic [DATA_W-1:0]    cyc_sum_reg, cyc_sum_next;
    logic [DATA_W-1:0]    part_sum_reg, part_sum_next;
    logic [DATA_W-1:0]    prod_reg, prod_next;
    logic [CYC_W-1:0]     idx_reg, idx_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 wrap_up_reg, wrap_up_next;
    logic                 wrap_dn_reg, wrap_dn_next;
    logic                 rd_ok_reg, rd_ok_next;

    logic [DATA_W-1:0] alu_a, alu_b, alu_res;
    logic              alu_cin;

    logic [4:0]        lsb_log2, fn_log2;
    logic [DATA_W-1:0] max_lsb, max_fn;
    logic              use_op;
    logic [DATA_W-1:0] eff_msb;
    logic signed [33:0] eff_lsb, cur_lsb, lsb_diff, half_lsb;
    logic [CYC_W:0]    rd_addr_wide;

    assign lsb_log2 = clamp_log2(cfg.log2_lsb);
    assign fn_log2  = clamp_log2(cfg.log2_fn);
    assign max_lsb  = DATA_W'(1) << lsb_log2;
    assign max_fn   = DATA_W'(1) << fn_log2;
    assign half_lsb = 34'sd1 <<< (lsb_log2 - 5'd1);

    assign use_op   = item_reg.has_reset_op && !item_reg.is_idr;
    assign eff_msb  = use_op ? '0 : prev_msb_reg;
    assign eff_lsb  = use_op ? (item_reg.is_bottom ? 34'sd0 : {{2{top_reg[31]}}, top_reg})
                             : $signed({18'd0, prev_lsb_reg});
    assign cur_lsb  = $signed({18'd0, item_reg.order_lsb});
    assign lsb_diff = cur_lsb - eff_lsb;

    assign alu_res = alu_a + alu_b + {{(DATA_W-1){1'b0}}, alu_cin};

    assign rd_addr    = rd_addr_wide[TABLE_AW-1:0];
    assign rd_ok_next = int'(rd_addr_wide) < TABLE_DEPTH;

    always_comb begin
        logic [CYC_W:0]    rem_shift;
        logic [DATA_W-1:0] temp;
        logic [DATA_W-1:0] tbl_val;

        state_next    = state_reg;
        item_next     = item_reg;
        prev_msb_next = prev_msb_reg;
        prev_lsb_next = prev_lsb_reg;
        prev_fn_next  = prev_fn_reg;
        prev_fo_next  = prev_fo_reg;
        top_next      = top_reg;
        bot_next      = bot_reg;
        acc_next      = acc_reg;
        tmp_next      = tmp_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        cyc_sum_next  = cyc_sum_reg;
        part_sum_next = part_sum_reg;
        prod_next     = prod_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        wrap_up_next  = wrap_up_reg;
        wrap_dn_next  = wrap_dn_reg;
        alu_a         = acc_reg;
        alu_b         = '0;
        alu_cin       = 1'b0;
        rd_addr_wide  = '0;
        rem_shift     = {r_reg, q_reg[DATA_W-1]};
        temp          = '0;
        tbl_val       = rd_ok_reg ? rd_data : '0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    item_next = item_in;
                    if (item_in.mode == MODE_DECODE && item_in.is_idr) begin
                        prev_msb_next = '0;
                        prev_lsb_next = '0;
                        prev_fn_next  = '0;
                        prev_fo_next  = '0;
                    end
                    if (item_in.mode == MODE_LOAD) begin
                        state_next = S_DONE;
                    end else begin
                        unique case (cfg.poc_type)
                            POC_TYPE_LSB:    state_next = S_M0_CMP;
                            POC_TYPE_FRAME:  state_next = S_FNO;
                            POC_TYPE_DOUBLE: state_next = S_FNO;
                            default:         state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_M0_CMP: begin
                wrap_up_next = lsb_diff <= -half_lsb;
                wrap_dn_next = lsb_diff > half_lsb;
                state_next   = S_M0_MSB;
            end
            S_M0_MSB: begin
                alu_a = eff_msb;
                if (wrap_up_reg) begin
                    alu_b = max_lsb;
                end else if (wrap_dn_reg) begin
                    alu_b   = ~max_lsb;
                    alu_cin = 1'b1;
                end
                prev_msb_next = alu_res;
                state_next    = S_M0_TOP;
            end
            S_M0_TOP: begin
                alu_a    = prev_msb_reg;
                alu_b    = {16'd0, item_reg.order_lsb};
                top_next = alu_res;
                if (item_reg.is_field) begin
                    bot_next   = alu_res;
                    state_next = S_DONE;
                end else begin
                    state_next = S_M0_BOT;
                end
            end
            S_M0_BOT: begin
                alu_a      = top_reg;
                alu_b      = item_reg.delta_bottom;
                bot_next   = alu_res;
                state_next = S_DONE;
            end
            S_FNO: begin
                alu_a        = prev_fo_reg;
                alu_b        = (prev_fn_reg > item_reg.frame_number) ? max_fn : '0;
                prev_fo_next = alu_res;
                state_next   = (cfg.poc_type == POC_TYPE_FRAME) ? S_M1_ABS : S_M2_SUM;
            end
            S_M2_SUM: begin
                alu_a      = prev_fo_reg;
                alu_b      = {16'd0, item_reg.frame_number};
                tmp_next   = alu_res;
                state_next = S_M2_TEMP;
            end
            S_M2_TEMP: begin
                alu_a = {tmp_reg[DATA_W-2:0], 1'b0};
                alu_b = item_reg.is_reference ? '0 : '1;
                temp  = item_reg.is_idr ? '0 : alu_res;
                if (!item_reg.is_field) begin
                    top_next = temp;
                    bot_next = temp;
                end else if (item_reg.is_bottom) begin
                    bot_next = temp;
                end else begin
                    top_next = temp;
                end
                state_next = S_DONE;
            end
            S_M1_ABS: begin
                alu_a      = prev_fo_reg;
                alu_b      = {16'd0, item_reg.frame_number};
                acc_next   = (cfg.cycle_len != '0) ? alu_res : '0;
                state_next = S_M1_DEC;
            end
            S_M1_DEC: begin
                alu_a = acc_reg;
                alu_b = '1;
                if (!item_reg.is_reference && $signed(acc_reg) > 0) begin
                    acc_next = alu_res;
                end
                state_next = S_M1_ADJ;
            end
            S_M1_ADJ: begin
                alu_a = acc_reg;
                alu_b = '1;
                if ($signed(acc_reg) > 0 && cfg.cycle_len != '0) begin
                    q_next     = alu_res;
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = S_M1_DIV;
                end else begin
                    acc_next   = '0;
                    state_next = S_M1_NREF;
                end
            end
            S_M1_DIV: begin
                alu_a   = {{(DATA_W-CYC_W-1){1'b0}}, rem_shift};
                alu_b   = ~{{(DATA_W-CYC_W){1'b0}}, cfg.cycle_len};
                alu_cin = 1'b1;
                if (!alu_res[DATA_W-1]) begin
                    r_next = alu_res[CYC_W-1:0];
                    q_next = {q_reg[DATA_W-2:0], 1'b1};
                end else begin
                    r_next = rem_shift[CYC_W-1:0];
                    q_next = {q_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_M1_PRIME;
                end
            end
            S_M1_PRIME: begin
                rd_addr_wide = '0;
                idx_next     = '0;
                cyc_sum_next = '0;
                state_next   = S_M1_SWEEP;
            end
            S_M1_SWEEP: begin
                rd_addr_wide = {1'b0, idx_reg} + 1'b1;
                alu_a        = cyc_sum_reg;
                alu_b        = tbl_val;
                cyc_sum_next = alu_res;
                if (idx_reg == r_reg) begin
                    part_sum_next = alu_res;
                end
                if (idx_reg == cfg.cycle_len - 1'b1) begin
                    state_next = S_M1_MUL;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_M1_MUL: begin
                prod_next  = q_reg * cyc_sum_reg;
                state_next = S_M1_EXP;
            end
            S_M1_EXP: begin
                alu_a      = prod_reg;
                alu_b      = part_sum_reg;
                acc_next   = alu_res;
                state_next = S_M1_NREF;
            end
            S_M1_NREF: begin
                alu_a = acc_reg;
                alu_b = cfg.nonref_off;
                if (!item_reg.is_reference) begin
                    acc_next = alu_res;
                end
                state_next = S_M1_TOP;
            end
            S_M1_TOP: begin
                alu_a = acc_reg;
                alu_b = item_reg.delta_first;
                if (item_reg.is_field && item_reg.is_bottom) begin
                    state_next = S_M1_BOT1;
                end else if (item_reg.is_field) begin
                    top_next   = alu_res;
                    state_next = S_DONE;
                end else begin
                    top_next   = alu_res;
                    state_next = S_M1_BOT1;
                end
            end
            S_M1_BOT1: begin
                alu_a      = item_reg.is_field ? acc_reg : top_reg;
                alu_b      = cfg.ttb_off;
                tmp_next   = alu_res;
                state_next = S_M1_BOT2;
            end
            S_M1_BOT2: begin
                alu_a      = tmp_reg;
                alu_b      = item_reg.is_field ? item_reg.delta_first : item_reg.delta_bottom;
                bot_next   = alu_res;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    if (item_reg.mode == MODE_DECODE) begin
                        prev_lsb_next = item_reg.order_lsb;
                        prev_fn_next  = item_reg.frame_number;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            prev_msb_reg <= '0;
            prev_lsb_reg <= '0;
            prev_fn_reg  <= '0;
            prev_fo_reg  <= '0;
            top_reg      <= '0;
            bot_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            prev_msb_reg <= prev_msb_next;
            prev_lsb_reg <= prev_lsb_next;
            prev_fn_reg  <= prev_fn_next;
            prev_fo_reg  <= prev_fo_next;
            top_reg      <= top_next;
            bot_reg      <= bot_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        acc_reg      <= acc_next;
        tmp_reg      <= tmp_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        cyc_sum_reg  <= cyc_sum_next;
        part_sum_reg <= part_sum_next;
        prod_reg     <= prod_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        wrap_up_reg  <= wrap_up_next;
        wrap_dn_reg  <= wrap_dn_next;
        rd_ok_reg    <= rd_ok_next;
    end

    assign status.idle  = (state_reg == S_IDLE);
    assign status.done  = (state_reg == S_DONE);
    assign top_count    = top_reg;
    assign bottom_count = bot_reg;

endmodule

FILE: design/picture_order_count_decoder_top.sv
// ----------------------------------------------------------------------------
// picture_order_count_decoder_top
// H.264 picture order count for one picture per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration registers are written through cfg_we/cfg_index/cfg_wdata
//   while the block is idle. Each input transaction (s_valid/s_ready) either
//   loads one offset table entry (s_mode = 0) or decodes one picture
//   (s_mode = 1); every transaction returns one result transaction
//   (m_valid/m_ready) holding the top and bottom order counts.
// Sequence, accept to result valid:
//   a table load or an unsupported method goes straight to the result;
//   method 1 takes longest, bounded by the 32 steps of the divider on the
//   shared adder and the sweep of the offset table, one entry per cycle
//   through its single read port.
//   One transaction is in work at a time; s_ready is high when idle, from the
//   cycle after the result loads into the output register.
// Reset: all picture history and the order counts clear to zero and the
//   registers take their defaults; the offset table is undefined until
//   loaded.
// Stall: a result waits in the output register; the next transaction is
//   accepted and computed meanwhile, then holds until the register frees.
// ----------------------------------------------------------------------------
module picture_order_count_decoder_top
    import poc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [7:0]           s_table_index,
    input  logic signed [31:0]   s_table_value,
    input  logic                 s_is_idr,
    input  logic [15:0]          s_frame_number,
    input  logic [15:0]          s_order_lsb,
    input  logic signed [31:0]   s_delta_first,
    input  logic signed [31:0]   s_delta_bottom,
    input  logic                 s_is_reference,
    input  logic                 s_is_field,
    input  logic                 s_is_bottom,
    input  logic                 s_has_reset_op,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_top_order_count,
    output logic signed [31:0]   m_bottom_order_count
);

    poc_cfg_t    cfg_reg, cfg_next;
    poc_item_t   item_in;
    poc_status_t status;

    logic                start;
    logic                tbl_we;
    logic [TABLE_AW-1:0] rd_addr;
    logic [DATA_W-1:0]   rd_data;
    logic [DATA_W-1:0]   top_count, bottom_count;
    logic                out_free, out_load;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_top_reg, m_top_next;
    logic [DATA_W-1:0] m_bot_reg, m_bot_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_ORDER_COUNT_TYPE:  cfg_next.poc_type   = cfg_wdata[1:0];
                REG_LOG2_MAX_LSB:      cfg_next.log2_lsb   = cfg_wdata[4:0];
                REG_LOG2_MAX_FRAME:    cfg_next.log2_fn    = cfg_wdata[4:0];
                REG_CYCLE_LENGTH:      cfg_next.cycle_len  = cfg_wdata[CYC_W-1:0];
                REG_NON_REF_OFFSET:    cfg_next.nonref_off = cfg_wdata;
                REG_TOP_BOTTOM_OFFSET: cfg_next.ttb_off    = cfg_wdata;
                default:               cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poc_type   <= POC_TYPE_LSB;
            cfg_reg.log2_lsb   <= LOG2_MIN;
            cfg_reg.log2_fn    <= LOG2_MIN;
            cfg_reg.cycle_len  <= '0;
            cfg_reg.nonref_off <= '0;
            cfg_reg.ttb_off    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = status.idle;
    assign start   = s_valid && s_ready;
    assign tbl_we  = start && (s_mode == MODE_LOAD) && (int'(s_table_index) < TABLE_DEPTH);

    assign item_in.mode         = s_mode;
    assign item_in.is_idr       = s_is_idr;
    assign item_in.frame_number = s_frame_number;
    assign item_in.order_lsb    = s_order_lsb;
    assign item_in.delta_first  = s_delta_first;
    assign item_in.delta_bottom = s_delta_bottom;
    assign item_in.is_reference = s_is_reference;
    assign item_in.is_field     = s_is_field;
    assign item_in.is_bottom    = s_is_bottom;
    assign item_in.has_reset_op = s_has_reset_op;

    poc_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (DATA_W),
        .AW    (TABLE_AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (s_table_index[TABLE_AW-1:0]),
        .wr_data (s_table_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    poc_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .start        (start),
        .item_in      (item_in),
        .out_free     (out_free),
        .status       (status),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .top_count    (top_count),
        .bottom_count (bottom_count)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = status.done && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_top_next   = m_top_reg;
        m_bot_next   = m_bot_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_top_next   = top_count;
            m_bot_next   = bottom_count;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_top_reg <= m_top_next;
        m_bot_reg <= m_bot_next;
    end

    assign m_valid              = m_valid_reg;
    assign m_top_order_count    = m_top_reg;
    assign m_bottom_order_count = m_bot_reg;

endmodule

FILE: dv/picture_order_count_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// picture_order_count_decoder_top_tb
// Self-checking bench for the picture order count decoder. A directed table
// covers load transactions, all three order count methods, the unsupported
// method, IDR and reset-op history, field pairs and frame number wrap. Random
// phases follow under several register settings. Each result is scored against
// an in-bench predictor or fixed counts, with random idling on both channels.
// ----------------------------------------------------------------------------
module picture_order_count_decoder_top_tb;
    import poc_pkg::*;

    localparam logic [1:0] POC_TYPE_INVALID = 2'd3;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic        mode;
        logic [7:0]  tbl_idx;
        logic [31:0] tbl_val;
        logic        is_idr;
        logic [15:0] frame_no;
        logic [15:0] order_lsb;
        logic [31:0] delta_first;
        logic [31:0] delta_bottom;
        logic        is_reference;
        logic        is_field;
        logic        is_bottom;
        logic        has_reset_op;
    } pic_txn_t;

    typedef struct packed {
        logic [31:0] top;
        logic [31:0] bot;
    } counts_t;

    typedef struct {
        logic [1:0] meth;
        pic_txn_t   t;
        logic       known;
        counts_t    exp_counts;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_mode;
    logic [7:0]           s_table_index;
    logic [31:0]          s_table_value;
    logic                 s_is_idr;
    logic [15:0]          s_frame_number;
    logic [15:0]          s_order_lsb;
    logic [31:0]          s_delta_first;
    logic [31:0]          s_delta_bottom;
    logic                 s_is_reference;
    logic                 s_is_field;
    logic                 s_is_bottom;
    logic                 s_has_reset_op;
    logic                 m_valid;
    logic                 m_ready;
    logic [31:0]          m_top_order_count;
    logic [31:0]          m_bottom_order_count;

    // register mirror
    logic [1:0]  cf_type;
    logic [4:0]  cf_log2_lsb;
    logic [4:0]  cf_log2_fn;
    logic [7:0]  cf_cycle;
    logic [31:0] cf_nonref;
    logic [31:0] cf_ttb;

    // picture history
    logic [31:0] offset_tbl [0:TABLE_DEPTH-1];
    logic [31:0] prev_msb;
    logic [15:0] prev_lsb;
    logic [15:0] prev_fn;
    logic [31:0] prev_fno;
    logic [31:0] top_cnt;
    logic [31:0] bot_cnt;

    // stimulus sequence trackers
    logic [31:0] seq_lsb;
    logic [31:0] seq_fn;
    logic        bottom_due;

    counts_t  pending_counts [$];
    counts_t  want_counts;
    dir_row_t dir_rows [$];
    int       n_in;
    int       n_out;
    int       n_mismatch;
    int       stall_cycles;

    picture_order_count_decoder_top u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_mode               (s_mode),
        .s_table_index        (s_table_index),
        .s_table_value        (s_table_value),
        .s_is_idr             (s_is_idr),
        .s_frame_number       (s_frame_number),
        .s_order_lsb          (s_order_lsb),
        .s_delta_first        (s_delta_first),
        .s_delta_bottom       (s_delta_bottom),
        .s_is_reference       (s_is_reference),
        .s_is_field           (s_is_field),
        .s_is_bottom          (s_is_bottom),
        .s_has_reset_op       (s_has_reset_op),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_top_order_count    (m_top_order_count),
        .m_bottom_order_count (m_bottom_order_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [4:0] lim_log2(input logic [4:0] v);
        return (v < LOG2_MIN) ? LOG2_MIN : ((v > LOG2_MAX) ? LOG2_MAX : v);
    endfunction

    function automatic counts_t predict_order_counts(input pic_txn_t t);
        counts_t     r;
        logic [31:0] fno, pmsb, msb, max_lsb, expv, per_cycle, a, n_cyc, pos, temp;
        longint      prev_l, cur_l, half_l, abs_frame;
        if (t.mode == MODE_LOAD) begin
            offset_tbl[t.tbl_idx] = t.tbl_val;
        end else begin
            if (t.is_idr) begin
                prev_fn  = '0;
                prev_fno = '0;
                prev_msb = '0;
                prev_lsb = '0;
            end
            if (t.is_idr) begin
                fno = '0;
            end else if (prev_fn > t.frame_no) begin
                fno = prev_fno + (32'd1 << lim_log2(cf_log2_fn));
            end else begin
                fno = prev_fno;
            end
            case (cf_type)
                POC_TYPE_LSB: begin
                    cur_l = t.order_lsb;
                    if (t.is_idr) begin
                        pmsb   = '0;
                        prev_l = 0;
                    end else if (t.has_reset_op) begin
                        pmsb = '0;
                        if (t.is_bottom) begin
                            prev_l = 0;
                        end else begin
                            prev_l = $signed(top_cnt);
                        end
                    end else begin
                        pmsb   = prev_msb;
                        prev_l = prev_lsb;
                    end
                    max_lsb = 32'd1 << lim_log2(cf_log2_lsb);
                    half_l  = max_lsb >> 1;
                    if (cur_l < prev_l && (prev_l - cur_l) >= half_l) begin
                        msb = pmsb + max_lsb;
                    end else if (cur_l > prev_l && (cur_l - prev_l) > half_l) begin
                        msb = pmsb - max_lsb;
                    end else begin
                        msb = pmsb;
                    end
                    top_cnt = msb + {16'd0, t.order_lsb};
                    if (t.is_field) begin
                        bot_cnt = top_cnt;
                    end else begin
                        bot_cnt = top_cnt + t.delta_bottom;
                    end
                    prev_msb = msb;
                end
                POC_TYPE_FRAME: begin
                    abs_frame = 0;
                    expv      = '0;
                    if (cf_cycle != 0) begin
                        abs_frame = $signed(fno + {16'd0, t.frame_no});
                    end
                    if (!t.is_reference && abs_frame > 0) begin
                        abs_frame = abs_frame - 1;
                    end
                    if (abs_frame > 0 && cf_cycle != 0) begin
                        a         = abs_frame[31:0] - 32'd1;
                        n_cyc     = a / {24'd0, cf_cycle};
                        pos       = a % {24'd0, cf_cycle};
                        per_cycle = '0;
                        for (int i = 0; i < cf_cycle; i++) begin
                            per_cycle = per_cycle + offset_tbl[i];
                        end
                        expv = n_cyc * per_cycle;
                        for (int i = 0; i <= pos; i++) begin
                            expv = expv + offset_tbl[i];
                        end
                    end
                    if (!t.is_reference) begin
                        expv = expv + cf_nonref;
                    end
                    if (!t.is_field) begin
                        top_cnt = expv + t.delta_first;
                        bot_cnt = top_cnt + cf_ttb + t.delta_bottom;
                    end else if (!t.is_bottom) begin
                        top_cnt = expv + t.delta_first;
                    end else begin
                        bot_cnt = expv + cf_ttb + t.delta_first;
                    end
                    prev_fno = fno;
                end
                POC_TYPE_DOUBLE: begin
                    if (t.is_idr) begin
                        temp = '0;
                    end else if (!t.is_reference) begin
                        temp = 32'd2 * (fno + {16'd0, t.frame_no}) - 32'd1;
                    end else begin
                        temp = 32'd2 * (fno + {16'd0, t.frame_no});
                    end
                    if (!t.is_field) begin
                        top_cnt = temp;
                        bot_cnt = temp;
                    end else if (t.is_bottom) begin
                        bot_cnt = temp;
                    end else begin
                        top_cnt = temp;
                    end
                    prev_fno = fno;
                end
                default: ;
            endcase
            prev_lsb = t.order_lsb;
            prev_fn  = t.frame_no;
        end
        r.top = top_cnt;
        r.bot = bot_cnt;
        return r;
    endfunction

    function automatic logic [31:0] wide_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3, 4:    return $urandom;
            default: return $urandom_range(16) - 8;
        endcase
    endfunction

    function automatic logic [31:0] small_or_wide();
        return ($urandom_range(4) == 0) ? wide_value() : $urandom_range(16) - 8;
    endfunction

    function automatic pic_txn_t next_picture();
        pic_txn_t    t;
        logic [31:0] lsb_mod, fn_mod;
        int unsigned pick;
        pick           = $urandom_range(99);
        lsb_mod        = 32'd1 << lim_log2(cf_log2_lsb);
        fn_mod         = 32'd1 << lim_log2(cf_log2_fn);
        t.mode         = MODE_DECODE;
        t.tbl_idx      = 8'($urandom);
        t.tbl_val      = $urandom;
        t.is_idr       = 1'($urandom_range(1));
        t.frame_no     = 16'($urandom);
        t.order_lsb    = 16'($urandom);
        t.delta_first  = $urandom;
        t.delta_bottom = $urandom;
        t.is_reference = 1'($urandom_range(1));
        t.is_field     = 1'($urandom_range(1));
        t.is_bottom    = 1'($urandom_range(1));
        t.has_reset_op = 1'($urandom_range(1));
        if (pick < 8) begin
            t.mode    = MODE_LOAD;
            t.tbl_val = wide_value();
        end else if (pick >= 20) begin
            if (bottom_due) begin
                t.is_idr       = 1'b0;
                t.has_reset_op = 1'b0;
                t.is_field     = 1'b1;
                t.is_bottom    = 1'b1;
                bottom_due     = 1'b0;
                seq_lsb        = (seq_lsb + 32'd1) & (lsb_mod - 32'd1);
            end else begin
                t.is_idr       = ($urandom_range(19) == 0);
                t.has_reset_op = !t.is_idr && ($urandom_range(24) == 0);
                t.is_field     = ($urandom_range(3) == 0);
                t.is_bottom    = 1'b0;
                bottom_due     = t.is_field;
                if (t.is_idr) begin
                    seq_lsb = '0;
                    seq_fn  = '0;
                end else if ($urandom_range(4) == 0) begin
                    seq_lsb = (seq_lsb + $urandom_range(lsb_mod - 1)) & (lsb_mod - 32'd1);
                    seq_fn  = (seq_fn + $urandom_range(fn_mod - 1)) & (fn_mod - 32'd1);
                end else begin
                    seq_lsb = (seq_lsb + $urandom_range(4)) & (lsb_mod - 32'd1);
                    seq_fn  = (seq_fn + $urandom_range(2)) & (fn_mod - 32'd1);
                end
            end
            t.order_lsb    = seq_lsb[15:0];
            t.frame_no     = seq_fn[15:0];
            t.is_reference = ($urandom_range(3) != 0);
            t.delta_first  = small_or_wide();
            t.delta_bottom = small_or_wide();
        end
        return t;
    endfunction

    function automatic int unsigned sender_idle_pct();
        return (n_in < 200) ? 36 : ((n_in < 400) ? 76 : 0);
    endfunction

    function automatic int unsigned receiver_idle_pct();
        return (n_in < 200) ? 76 : ((n_in < 400) ? 36 : 0);
    endfunction

    function automatic dir_row_t load_row(input logic [7:0] idx, input logic [31:0] val);
        dir_row_t r;
        r.meth      = POC_TYPE_LSB;
        r.t         = '0;
        r.t.mode    = MODE_LOAD;
        r.t.tbl_idx = idx;
        r.t.tbl_val = val;
        r.known     = 1'b0;
        r.exp_counts = '0;
        return r;
    endfunction

    function automatic dir_row_t pic_row(input logic [1:0] meth, input logic idr,
                                         input logic [15:0] fn, lsb,
                                         input logic [31:0] df, db,
                                         input logic is_ref, fld, bot, rst);
        dir_row_t r;
        r.meth           = meth;
        r.t              = '0;
        r.t.mode         = MODE_DECODE;
        r.t.is_idr       = idr;
        r.t.frame_no     = fn;
        r.t.order_lsb    = lsb;
        r.t.delta_first  = df;
        r.t.delta_bottom = db;
        r.t.is_reference = is_ref;
        r.t.is_field     = fld;
        r.t.is_bottom    = bot;
        r.t.has_reset_op = rst;
        r.known          = 1'b0;
        r.exp_counts     = '0;
        return r;
    endfunction

    function automatic dir_row_t known(input dir_row_t r, input logic [31:0] top, bot);
        dir_row_t k;
        k                = r;
        k.known          = 1'b1;
        k.exp_counts.top = top;
        k.exp_counts.bot = bot;
        return k;
    endfunction

    task automatic flag_mismatch(input string what);
        n_mismatch++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
        case (idx)
            REG_ORDER_COUNT_TYPE:  cf_type     = val[1:0];
            REG_LOG2_MAX_LSB:      cf_log2_lsb = val[4:0];
            REG_LOG2_MAX_FRAME:    cf_log2_fn  = val[4:0];
            REG_CYCLE_LENGTH:      cf_cycle    = val[7:0];
            REG_NON_REF_OFFSET:    cf_nonref   = val;
            REG_TOP_BOTTOM_OFFSET: cf_ttb      = val;
            default: ;
        endcase
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (pending_counts.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic send_picture(input pic_txn_t t, input logic has_exp,
                                input counts_t exp_counts);
        counts_t got;
        while ($urandom_range(99) < sender_idle_pct()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_mode         = t.mode;
        s_table_index  = t.tbl_idx;
        s_table_value  = t.tbl_val;
        s_is_idr       = t.is_idr;
        s_frame_number = t.frame_no;
        s_order_lsb    = t.order_lsb;
        s_delta_first  = t.delta_first;
        s_delta_bottom = t.delta_bottom;
        s_is_reference = t.is_reference;
        s_is_field     = t.is_field;
        s_is_bottom    = t.is_bottom;
        s_has_reset_op = t.has_reset_op;
        s_valid        = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        got = predict_order_counts(t);
        pending_counts.push_back(has_exp ? exp_counts : got);
        n_in++;
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic [1:0] meth, input logic [4:0] lsb_w, fn_w,
                             input logic [7:0] cyc, input logic [31:0] nonref, ttb,
                             input int count);
        settle();
        set_reg(REG_ORDER_COUNT_TYPE, {30'd0, meth});
        set_reg(REG_LOG2_MAX_LSB, {27'd0, lsb_w});
        set_reg(REG_LOG2_MAX_FRAME, {27'd0, fn_w});
        set_reg(REG_CYCLE_LENGTH, {24'd0, cyc});
        set_reg(REG_NON_REF_OFFSET, nonref);
        set_reg(REG_TOP_BOTTOM_OFFSET, ttb);
        bottom_due = 1'b0;
        repeat (count) send_picture(next_picture(), 1'b0, '0);
    endtask

    // result scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                flag_mismatch($sformatf("result %0d with no transaction pending", n_out));
            end else begin
                want_counts = pending_counts.pop_front();
                if (m_top_order_count !== want_counts.top) begin
                    flag_mismatch($sformatf("result %0d top %0d, want %0d", n_out,
                                  $signed(m_top_order_count), $signed(want_counts.top)));
                end
                if (m_bottom_order_count !== want_counts.bot) begin
                    flag_mismatch($sformatf("result %0d bottom %0d, want %0d", n_out,
                                  $signed(m_bottom_order_count), $signed(want_counts.bot)));
                end
            end
            n_out++;
        end
    end

    // receiver that holds off long at result HOLD_AT to back the block up
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (n_out == HOLD_AT) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready = ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        dir_row_t fill_row;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_mode         = MODE_LOAD;
        s_table_index  = '0;
        s_table_value  = '0;
        s_is_idr       = 1'b0;
        s_frame_number = '0;
        s_order_lsb    = '0;
        s_delta_first  = '0;
        s_delta_bottom = '0;
        s_is_reference = 1'b0;
        s_is_field     = 1'b0;
        s_is_bottom    = 1'b0;
        s_has_reset_op = 1'b0;
        cf_type        = POC_TYPE_LSB;
        cf_log2_lsb    = 5'd4;
        cf_log2_fn     = 5'd4;
        cf_cycle       = '0;
        cf_nonref      = '0;
        cf_ttb         = '0;
        prev_msb       = '0;
        prev_lsb       = '0;
        prev_fn        = '0;
        prev_fno       = '0;
        top_cnt        = '0;
        bot_cnt        = '0;
        seq_lsb        = '0;
        seq_fn         = '0;
        bottom_due     = 1'b0;
        n_in           = 0;
        n_out          = 0;
        n_mismatch     = 0;
        stall_cycles   = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        set_reg(REG_CYCLE_LENGTH, 32'd2);
        set_reg(REG_NON_REF_OFFSET, -32'sd7);
        set_reg(REG_TOP_BOTTOM_OFFSET, 32'd100);

        // method 1 at cycle length 2 reads entries 0 and 1, loaded first
        dir_rows.push_back(known(load_row(8'd0, 32'd5), 0, 0));
        dir_rows.push_back(known(load_row(8'd1, -32'sd3), 0, 0));
        dir_rows.push_back(known(load_row(8'd255, 32'h7FFF_FFFF), 0, 0));
        dir_rows.push_back(known(pic_row(POC_TYPE_LSB, 1, 0, 0, 0, 0, 1, 0, 0, 0), 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_LSB, 0, 1, 15, 0, 3, 1, 0, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_LSB, 0, 2, 16'hFFFF, 0, 32'h7FFF_FFFF, 1, 0, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_LSB, 0, 3, 3, 0, 32'h8000_0000, 1, 1, 0, 1));
        dir_rows.push_back(pic_row(POC_TYPE_LSB, 0, 3, 9, 0, 0, 1, 1, 1, 1));
        dir_rows.push_back(pic_row(POC_TYPE_LSB, 0, 4, 12, 0, 0, 0, 1, 1, 0));
        dir_rows.push_back(known(pic_row(POC_TYPE_FRAME, 1, 0, 0, 0, 0, 1, 0, 0, 0), 0, 100));
        dir_rows.push_back(pic_row(POC_TYPE_FRAME, 0, 3, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                                   1, 0, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_FRAME, 0, 5, 0, 4, 0, 0, 1, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_FRAME, 0, 6, 0, -32'sd2, 0, 1, 1, 1, 0));
        dir_rows.push_back(pic_row(POC_TYPE_FRAME, 0, 1, 0, 1, 2, 0, 0, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_FRAME, 0, 16'hFFFF, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(known(pic_row(POC_TYPE_DOUBLE, 1, 0, 0, 0, 0, 1, 0, 0, 0), 0, 0));
        dir_rows.push_back(known(pic_row(POC_TYPE_DOUBLE, 0, 5, 0, 0, 0, 1, 0, 0, 0), 10, 10));
        dir_rows.push_back(pic_row(POC_TYPE_DOUBLE, 0, 2, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_DOUBLE, 0, 16'hFFFF, 0, 0, 0, 1, 1, 1, 0));
        dir_rows.push_back(pic_row(POC_TYPE_DOUBLE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_INVALID, 1, 9, 7, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_INVALID, 0, 4, 11, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_LSB, 0, 5, 13, 0, -32'sd1, 1, 0, 0, 0));
        dir_rows.push_back(pic_row(POC_TYPE_LSB, 1, 0, 16'h8000, 0, 0, 1, 0, 0, 0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].t.mode == MODE_DECODE && dir_rows[i].meth != cf_type) begin
                settle();
                set_reg(REG_ORDER_COUNT_TYPE, {30'd0, dir_rows[i].meth});
            end
            send_picture(dir_rows[i].t, dir_rows[i].known, dir_rows[i].exp_counts);
        end

        // fill the whole offset table so any cycle length reads written entries
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            fill_row = load_row(i[7:0], wide_value());
            send_picture(fill_row.t, 1'b0, '0);
        end

        run_phase(POC_TYPE_LSB, 5'd4, 5'd4, 8'd3, $urandom, $urandom, 30);
        run_phase(POC_TYPE_LSB, 5'd16, 5'd16, 8'd0, 32'd0, 32'd0, 30);
        run_phase(POC_TYPE_LSB, 5'd0, 5'd31, 8'd1, 32'd1, 32'd1, 15);
        run_phase(POC_TYPE_LSB, 5'd31, 5'd0, 8'd2, 32'd2, 32'd2, 15);
        run_phase(POC_TYPE_FRAME, 5'd4, 5'd31, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 20);
        run_phase(POC_TYPE_FRAME, 5'd8, 5'd0, 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 20);
        run_phase(POC_TYPE_FRAME, 5'($urandom_range(4, 16)), 5'($urandom_range(4, 16)),
                  8'($urandom_range(2, 20)), wide_value(), wide_value(), 40);
        run_phase(POC_TYPE_FRAME, 5'd4, 5'd16, 8'd255, wide_value(), wide_value(), 10);
        run_phase(POC_TYPE_DOUBLE, 5'd4, 5'd4, 8'd0, 32'd0, 32'd0, 25);
        run_phase(POC_TYPE_DOUBLE, 5'd4, 5'd16, 8'd0, 32'd0, 32'd0, 20);
        run_phase(POC_TYPE_DOUBLE, 5'd4, 5'd2, 8'd0, 32'd0, 32'd0, 10);
        run_phase(POC_TYPE_INVALID, 5'd16, 5'd16, 8'd4, 32'd0, 32'd0, 10);
        run_phase(POC_TYPE_LSB, 5'($urandom_range(4, 16)), 5'($urandom_range(4, 16)), 8'd0,
                  32'd0, 32'd0, 30);
        run_phase(POC_TYPE_FRAME, 5'($urandom_range(4, 16)), 5'($urandom_range(4, 16)),
                  8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(8)),
                  wide_value(), wide_value(), 25);

        s_valid = 1'b0;
        while (pending_counts.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (n_mismatch == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: picture_order_count_decoder_top.f
design/poc_pkg.sv
design/poc_table_ram.sv
design/poc_seq.sv
design/picture_order_count_decoder_top.sv
dv/picture_order_count_decoder_top_tb.sv
